// ===== sv/hufd_pkg.sv =====
package hufd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN = 32;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int PLEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int CMP_W = (MAX_CODE_LEN > 32) ? MAX_CODE_LEN : 32;
  localparam int LEN_CMP_W = 7;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic [2:0] BIT_TOP = 3'd7;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      code;
    logic [5:0]       len;
    logic [7:0]       sym;
    logic             valid;
  } tbl_wr_t;

  typedef struct packed {
    logic [31:0] code;
    logic [5:0]  len;
    logic [7:0]  sym;
    logic        valid;
  } tbl_rd_t;

endpackage

// ===== sv/huffman_table_decoder.sv =====
// Huffman decoder with a code table that is loaded through the input channel.
// The input channel carries one request per item: cmd 0 writes one table entry
// (index, right-aligned code bits, length, symbol; a length of 0 or above the
// maximum code length leaves the entry invalid), cmd 1 decodes one byte, and
// cmd 2 drops the pending code bits. The output channel carries one result per
// decoded symbol or per unmatched code of maximum length, with last set on the
// final result caused by a byte; a byte that completes no code gives none.
// Each of the eight bits of a byte is looked up by a scan of the table memory,
// one entry per cycle from index 0, stopping at the first match. A decode
// request keeps the block busy until all eight bits are done; load and flush
// requests are handled in the idle state. One request is handled at a time.
// Results lag the bit that completes them by up to one code, since a result
// waits until the next one shows whether it is the last. Reset invalidates
// all table entries and clears the pending code at once. A stalled receiver
// holds the result register; the scan pauses when a further result must be
// placed, and no result is dropped.
module huffman_table_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  entry_index_i,
  input  logic [31:0] entry_code_i,
  input  logic [5:0]  entry_length_i,
  input  logic [7:0]  entry_symbol_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  symbol_o,
  output logic        error_o,
  output logic        last_o
);
  import hufd_pkg::*;

  tbl_wr_t          tbl_wr;
  tbl_rd_t          tbl_rd;
  logic             tbl_rd_en;
  logic [IDX_W-1:0] tbl_rd_idx;

  hufd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .entry_code_i   (entry_code_i),
    .entry_length_i (entry_length_i),
    .entry_symbol_i (entry_symbol_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .error_o        (error_o),
    .last_o         (last_o),
    .wr_o           (tbl_wr),
    .rd_en_o        (tbl_rd_en),
    .rd_idx_o       (tbl_rd_idx),
    .rd_i           (tbl_rd)
  );

  hufd_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_en_i  (tbl_rd_en),
    .rd_idx_i (tbl_rd_idx),
    .rd_o     (tbl_rd)
  );

endmodule

// ===== sv/hufd_table.sv =====
module hufd_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hufd_pkg::tbl_wr_t       wr_i,
  input  logic                    rd_en_i,
  input  logic [hufd_pkg::IDX_W-1:0] rd_idx_i,
  output hufd_pkg::tbl_rd_t       rd_o
);
  import hufd_pkg::*;

  typedef struct packed {
    logic [31:0] code;
    logic [5:0]  len;
    logic [7:0]  sym;
  } entry_t;

  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rd_data_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= '{code: wr_i.code, len: wr_i.len, sym: wr_i.sym};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= wr_i.valid;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_o.code  = rd_data_q.code;
  assign rd_o.len   = rd_data_q.len;
  assign rd_o.sym   = rd_data_q.sym;
  assign rd_o.valid = rd_valid_q;

endmodule

// ===== sv/hufd_ctrl.sv =====
module hufd_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic [7:0]                 entry_index_i,
  input  logic [31:0]                entry_code_i,
  input  logic [5:0]                 entry_length_i,
  input  logic [7:0]                 entry_symbol_i,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 symbol_o,
  output logic                       error_o,
  output logic                       last_o,
  output hufd_pkg::tbl_wr_t          wr_o,
  output logic                       rd_en_o,
  output logic [hufd_pkg::IDX_W-1:0] rd_idx_o,
  input  hufd_pkg::tbl_rd_t          rd_i
);
  import hufd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_PLACE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [7:0]              byte_q, byte_d;
  logic [2:0]              bit_q, bit_d;
  logic [MAX_CODE_LEN-1:0] pend_bits_q, pend_bits_d;
  logic [PLEN_W-1:0]       pend_len_q, pend_len_d;
  logic [CMP_W-1:0]        mask_q, mask_d;
  logic [IDX_W:0]          scan_q, scan_d;
  logic                    rvalid_q, rvalid_d;
  logic                    rlast_q, rlast_d;
  logic [7:0]              res_sym_q, res_sym_d;
  logic                    res_err_q, res_err_d;
  logic                    held_valid_q, held_valid_d;
  logic [7:0]              held_sym_q, held_sym_d;
  logic                    held_err_q, held_err_d;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              out_sym_q, out_sym_d;
  logic                    out_err_q, out_err_d;
  logic                    out_last_q, out_last_d;

  logic                    accept;
  logic                    out_free;
  logic                    hit;
  logic [MAX_CODE_LEN:0]   shifted;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign shifted  = {pend_bits_q, byte_q[bit_q]};

  assign hit = rvalid_q && rd_i.valid
            && (LEN_CMP_W'(rd_i.len) == LEN_CMP_W'(pend_len_q))
            && ((CMP_W'(rd_i.code) & mask_q) == CMP_W'(pend_bits_q));

  always_comb begin
    state_d      = state_q;
    byte_d       = byte_q;
    bit_d        = bit_q;
    pend_bits_d  = pend_bits_q;
    pend_len_d   = pend_len_q;
    mask_d       = mask_q;
    scan_d       = scan_q;
    rvalid_d     = 1'b0;
    rlast_d      = rlast_q;
    res_sym_d    = res_sym_q;
    res_err_d    = res_err_q;
    held_valid_d = held_valid_q;
    held_sym_d   = held_sym_q;
    held_err_d   = held_err_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sym_d    = out_sym_q;
    out_err_d    = out_err_q;
    out_last_d   = out_last_q;
    rd_en_o      = 1'b0;
    wr_o.en      = 1'b0;
    wr_o.idx     = entry_index_i[IDX_W-1:0];
    wr_o.code    = entry_code_i;
    wr_o.len     = entry_length_i;
    wr_o.sym     = entry_symbol_i;
    wr_o.valid   = (entry_length_i != 6'd0)
                && (LEN_CMP_W'(entry_length_i) <= LEN_CMP_W'(MAX_CODE_LEN));

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_LOAD: begin
              wr_o.en = (9'(entry_index_i) < 9'(TABLE_ENTRIES));
            end
            CMD_DECODE: begin
              byte_d  = data_byte_i;
              bit_d   = BIT_TOP;
              state_d = ST_SHIFT;
            end
            CMD_FLUSH: begin
              pend_bits_d = '0;
              pend_len_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        pend_bits_d = shifted[MAX_CODE_LEN-1:0];
        pend_len_d  = pend_len_q + 1'b1;
        mask_d      = ~({CMP_W{1'b1}} << pend_len_d);
        scan_d      = '0;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        rd_en_o  = (scan_q < (IDX_W + 1)'(TABLE_ENTRIES));
        rvalid_d = rd_en_o;
        rlast_d  = (scan_q == (IDX_W + 1)'(TABLE_ENTRIES - 1));
        if (rd_en_o) begin
          scan_d = scan_q + 1'b1;
        end
        if (hit) begin
          res_sym_d = rd_i.sym;
          res_err_d = 1'b0;
          rvalid_d  = 1'b0;
          state_d   = ST_PLACE;
        end else if (rvalid_q && rlast_q) begin
          rvalid_d = 1'b0;
          if (pend_len_q == PLEN_W'(MAX_CODE_LEN)) begin
            res_sym_d = 8'd0;
            res_err_d = 1'b1;
            state_d   = ST_PLACE;
          end else if (bit_q == 3'd0) begin
            state_d = ST_FINISH;
          end else begin
            bit_d   = bit_q - 1'b1;
            state_d = ST_SHIFT;
          end
        end
      end
      ST_PLACE: begin
        if (!held_valid_q || out_free) begin
          if (held_valid_q) begin
            out_valid_d = 1'b1;
            out_sym_d   = held_sym_q;
            out_err_d   = held_err_q;
            out_last_d  = 1'b0;
          end
          held_valid_d = 1'b1;
          held_sym_d   = res_sym_q;
          held_err_d   = res_err_q;
          pend_bits_d  = '0;
          pend_len_d   = '0;
          if (bit_q == 3'd0) begin
            state_d = ST_FINISH;
          end else begin
            bit_d   = bit_q - 1'b1;
            state_d = ST_SHIFT;
          end
        end
      end
      ST_FINISH: begin
        if (!held_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = held_sym_q;
          out_err_d    = held_err_q;
          out_last_d   = 1'b1;
          held_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_bits_q  <= '0;
      pend_len_q   <= '0;
      rvalid_q     <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_bits_q  <= pend_bits_d;
      pend_len_q   <= pend_len_d;
      rvalid_q     <= rvalid_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    bit_q      <= bit_d;
    mask_q     <= mask_d;
    scan_q     <= scan_d;
    rlast_q    <= rlast_d;
    res_sym_q  <= res_sym_d;
    res_err_q  <= res_err_d;
    held_sym_q <= held_sym_d;
    held_err_q <= held_err_d;
    out_sym_q  <= out_sym_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  assign rd_idx_o    = scan_q[IDX_W-1:0];
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign error_o     = out_err_q;
  assign last_o      = out_last_q;

endmodule

// ===== sv/hufd_checker.sv =====
module hufd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] cmd_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] symbol_o,
  input logic       error_o,
  input logic       last_o
);
  import hufd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(symbol_o)
      && $stable(error_o) && $stable(last_o))
    else $error("Result changed while stalled.");

  a_error_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> symbol_o == 8'd0)
    else $error("Error result carries a nonzero symbol.");

  a_decode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_DECODE |=> !in_ready_o)
    else $error("Decode request did not occupy the block.");

  a_no_result_from_control: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i != CMD_DECODE |=> !$rose(out_valid_o))
    else $error("Load or flush request produced a result.");

endmodule

bind huffman_table_decoder hufd_checker u_hufd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .symbol_o    (symbol_o),
  .error_o     (error_o),
  .last_o      (last_o)
);
